// File: rtl/zmtpdf_pkg.sv
// types, codes and rom contents shared by the handshake deframer
`timescale 1ns / 1ps

package zmtpdf_pkg;

	localparam int unsigned SIG_LEN   = 10;
	localparam int unsigned GREET_LEN = 53;

	localparam logic [7:0] VERSION_BYTE = 8'h03;

	// bit positions in the frame flags byte
	localparam int unsigned FLAG_MORE_BIT = 0;
	localparam int unsigned FLAG_LONG_BIT = 1;
	localparam int unsigned FLAG_CMD_BIT  = 2;

	localparam logic [5:0] SHORT_LEN_BYTES = 6'd1;
	localparam logic [5:0] LONG_LEN_BYTES  = 6'd8;

	typedef enum logic [2:0] {
		PH_SIG    = 3'd0,
		PH_VER    = 3'd1,
		PH_GREET  = 3'd2,
		PH_FLAGS  = 3'd3,
		PH_LEN    = 3'd4,
		PH_PAY    = 3'd5,
		PH_CLOSED = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_EMPTY   = 3'd2,
		EV_REPLY   = 3'd3,
		EV_ERROR   = 3'd4
	} event_t;

	localparam logic [1:0] REPLY_NONE     = 2'd0;
	localparam logic [1:0] REPLY_VERSION  = 2'd1;
	localparam logic [1:0] REPLY_GREETING = 2'd2;
	localparam logic [1:0] REPLY_READY    = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SIG      = 2'd1;
	localparam logic [1:0] ERR_VERSION  = 2'd2;
	localparam logic [1:0] ERR_GREETING = 2'd3;

	typedef struct packed {
		event_t     event_res;
		logic [7:0] data_byte;
		logic       frame_last;
		logic       more_frames;
		logic [1:0] reply_kind;
		logic [1:0] error_code;
	} result_t;

	function automatic logic [7:0] sig_rom(input logic [5:0] idx);
		logic [7:0] val;
		case (idx)
			6'd0:    val = 8'hFF;
			6'd8:    val = 8'h01;
			6'd9:    val = 8'h7F;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	// null mechanism name in the greeting, everything else zero
	function automatic logic [7:0] greet_rom(input logic [5:0] idx);
		logic [7:0] val;
		case (idx)
			6'd1:    val = 8'h4E;
			6'd2:    val = 8'h55;
			6'd3:    val = 8'h4C;
			6'd4:    val = 8'h4C;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

// File: rtl/zmtpdf_if.sv
// valid/ready channel interfaces for received bytes and results
`timescale 1ns / 1ps

interface zmtpdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface zmtpdf_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] data_byte;
	logic       frame_last;
	logic       more_frames;
	logic [1:0] reply_kind;
	logic [1:0] error_code;

	modport source (output valid, output event_res, output data_byte, output frame_last,
		output more_frames, output reply_kind, output error_code, input ready);
	modport sink (input valid, input event_res, input data_byte, input frame_last,
		input more_frames, input reply_kind, input error_code, output ready);
endinterface

// File: rtl/zmtp_null_handshake_deframer_top.sv
// handshake checker and frame parser for a peer using the null mechanism
//
// bytes:   received bytes, one request per byte (valid/ready)
// results: exactly one result per accepted byte, in order (valid/ready)
// every byte is checked and the parse state updated in the cycle it is
// accepted; its result sits in the output register the next cycle, and the
// throughput is 1 byte per cycle unless the results side holds back ready
// the signature, version and greeting stages each end with a reply request
// (send version, send greeting, send ready and connected) or, on any
// mismatch, an error close on the last byte of the stage; after that all
// bytes are swallowed with no event until reset
// in the data phase a flags byte and a 1 or 8 byte length precede the
// payload; payload bytes of data frames come out with last and more marks
// reset: parser returns to the signature stage, output register empties
// stall: bytes.ready follows the output register; a new byte is taken
// whenever the register is empty or is being read in the same cycle
`timescale 1ns / 1ps

module zmtp_null_handshake_deframer_top
	import zmtpdf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	zmtpdf_byte_if.sink       bytes,
	zmtpdf_result_if.source   results
);

	phase_t      phase_q, phase_d;
	logic [5:0]  byte_index_q, byte_index_d;
	logic        mismatch_q, mismatch_d;
	logic [2:0]  flags_q, flags_d;
	logic [63:0] length_q, length_d;
	logic [63:0] remaining_q, remaining_d;

	result_t     res_d, res_q;
	logic        valid_q;
	logic        accept;
	logic [7:0]  b;
	logic [5:0]  idx_inc;
	logic [5:0]  len_need;
	logic [63:0] length_shift;
	logic        sig_bad, greet_bad;

	assign b       = bytes.rx_byte;
	assign accept  = bytes.valid && bytes.ready;
	assign bytes.ready = !valid_q || results.ready;

	assign idx_inc      = byte_index_q + 6'd1;
	assign len_need     = flags_q[FLAG_LONG_BIT] ? LONG_LEN_BYTES : SHORT_LEN_BYTES;
	assign length_shift = {length_q[55:0], b};
	assign sig_bad      = (b != sig_rom(byte_index_q));
	assign greet_bad    = (b != greet_rom(byte_index_q));

	// next state
	always_comb begin
		phase_d      = phase_q;
		byte_index_d = byte_index_q;
		mismatch_d   = mismatch_q;
		flags_d      = flags_q;
		length_d     = length_q;
		remaining_d  = remaining_q;
		case (phase_q)
			PH_SIG: begin
				if (byte_index_q >= 6'(SIG_LEN - 1)) begin
					phase_d      = (mismatch_q || sig_bad) ? PH_CLOSED : PH_VER;
					byte_index_d = '0;
					mismatch_d   = 1'b0;
				end else begin
					byte_index_d = idx_inc;
					mismatch_d   = mismatch_q || sig_bad;
				end
			end
			PH_VER: begin
				phase_d      = (b == VERSION_BYTE) ? PH_GREET : PH_CLOSED;
				byte_index_d = '0;
				mismatch_d   = 1'b0;
			end
			PH_GREET: begin
				if (byte_index_q >= 6'(GREET_LEN - 1)) begin
					phase_d      = (mismatch_q || greet_bad) ? PH_CLOSED : PH_FLAGS;
					byte_index_d = '0;
					mismatch_d   = 1'b0;
				end else begin
					byte_index_d = idx_inc;
					mismatch_d   = mismatch_q || greet_bad;
				end
			end
			PH_FLAGS: begin
				flags_d      = b[2:0];
				length_d     = '0;
				byte_index_d = '0;
				phase_d      = PH_LEN;
			end
			PH_LEN: begin
				length_d     = length_shift;
				byte_index_d = idx_inc;
				if (idx_inc >= len_need) begin
					byte_index_d = '0;
					if (length_shift == '0) begin
						phase_d = PH_FLAGS;
					end else begin
						remaining_d = length_shift;
						phase_d     = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				if (remaining_q > 64'd1) begin
					remaining_d = remaining_q - 64'd1;
				end else begin
					remaining_d = '0;
					phase_d     = PH_FLAGS;
				end
			end
			default: begin
				phase_d = PH_CLOSED;
			end
		endcase
	end

	// result for the byte being accepted
	always_comb begin
		res_d = '{event_res: EV_NONE, data_byte: 8'd0, frame_last: 1'b0,
			more_frames: 1'b0, reply_kind: REPLY_NONE, error_code: ERR_NONE};
		case (phase_q)
			PH_SIG: begin
				if (byte_index_q >= 6'(SIG_LEN - 1)) begin
					if (mismatch_q || sig_bad) begin
						res_d.event_res  = EV_ERROR;
						res_d.error_code = ERR_SIG;
					end else begin
						res_d.event_res  = EV_REPLY;
						res_d.reply_kind = REPLY_VERSION;
					end
				end
			end
			PH_VER: begin
				if (b == VERSION_BYTE) begin
					res_d.event_res  = EV_REPLY;
					res_d.reply_kind = REPLY_GREETING;
				end else begin
					res_d.event_res  = EV_ERROR;
					res_d.error_code = ERR_VERSION;
				end
			end
			PH_GREET: begin
				if (byte_index_q >= 6'(GREET_LEN - 1)) begin
					if (mismatch_q || greet_bad) begin
						res_d.event_res  = EV_ERROR;
						res_d.error_code = ERR_GREETING;
					end else begin
						res_d.event_res  = EV_REPLY;
						res_d.reply_kind = REPLY_READY;
					end
				end
			end
			PH_LEN: begin
				// zero-length data frame, command frames stay silent
				if (idx_inc >= len_need && length_shift == '0 && !flags_q[FLAG_CMD_BIT]) begin
					res_d.event_res   = EV_EMPTY;
					res_d.more_frames = flags_q[FLAG_MORE_BIT];
				end
			end
			PH_PAY: begin
				if (!flags_q[FLAG_CMD_BIT]) begin
					res_d.event_res   = EV_PAYLOAD;
					res_d.data_byte   = b;
					res_d.frame_last  = (remaining_q <= 64'd1);
					res_d.more_frames = flags_q[FLAG_MORE_BIT];
				end
			end
			default: begin
				res_d.event_res = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIG;
			byte_index_q <= '0;
			mismatch_q   <= 1'b0;
			flags_q      <= '0;
			length_q     <= '0;
			remaining_q  <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				byte_index_q <= byte_index_d;
				mismatch_q   <= mismatch_d;
				flags_q      <= flags_d;
				length_q     <= length_d;
				remaining_q  <= remaining_d;
				valid_q      <= 1'b1;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign results.valid       = valid_q;
	assign results.event_res   = res_q.event_res;
	assign results.data_byte   = res_q.data_byte;
	assign results.frame_last  = res_q.frame_last;
	assign results.more_frames = res_q.more_frames;
	assign results.reply_kind  = res_q.reply_kind;
	assign results.error_code  = res_q.error_code;

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("closed state left before reset");

	a_sig_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SIG |-> byte_index_q < 6'(SIG_LEN))
		else $error("signature index past end");

	a_error_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((res_q.error_code != ERR_NONE) == (res_q.event_res == EV_ERROR)))
		else $error("error code without error close");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_d.event_res == EV_ERROR |=> phase_q == PH_CLOSED)
		else $error("error close did not enter closed state");

endmodule

// File: sim/zmtp_null_handshake_deframer_top_tb.sv
// self-checking testbench for the null handshake deframer top level
`timescale 1ns / 1ps

module zmtp_null_handshake_deframer_top_tb
	import zmtpdf_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 1150;
	localparam int CLOSED_TAIL    = 1200;

	localparam logic [7:0] SIG_PATTERN [SIG_LEN] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h01, 8'h7F};
	localparam logic [31:0] MECH_NAME = "NULL";

	typedef enum int {
		RUN_GOOD,
		RUN_BAD_SIG,
		RUN_BAD_VER,
		RUN_BAD_GREET
	} run_kind_t;

	logic clk;
	logic arst_n;

	zmtpdf_byte_if bytes_ch();
	zmtpdf_result_if res_ch();

	zmtp_null_handshake_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_ch),
		.results(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	logic [7:0] rx_stream [$];
	result_t expected_events [$];
	int total_bytes = 0;
	int bytes_taken = 0;
	int mismatches = 0;
	int idle_cycles;

	// parser shadow state
	phase_t parse_phase = PH_SIG;
	logic [5:0] stage_pos = '0;
	logic stage_bad = 1'b0;
	logic [2:0] frame_flags_q = '0;
	logic [63:0] len_acc = '0;
	logic [63:0] pay_left = '0;

	// last eighth of the stream runs with no idling
	function automatic bit in_tail();
		return rx_stream.size() * 8 < total_bytes;
	endfunction

	function automatic logic [7:0] greet_pattern(input int idx);
		return (idx >= 1 && idx <= 4) ? MECH_NAME[8 * (4 - idx) +: 8] : 8'h00;
	endfunction

	function automatic result_t parse_rx(input logic [7:0] b);
		result_t r;
		logic [5:0] need;
		r = '0;
		r.event_res = EV_NONE;
		case (parse_phase)
			PH_SIG: begin
				if (stage_pos < SIG_LEN && b != SIG_PATTERN[stage_pos])
					stage_bad = 1'b1;
				if (stage_pos >= SIG_LEN - 1) begin
					if (stage_bad) begin
						r.event_res = EV_ERROR;
						r.error_code = ERR_SIG;
						parse_phase = PH_CLOSED;
					end else begin
						r.event_res = EV_REPLY;
						r.reply_kind = REPLY_VERSION;
						parse_phase = PH_VER;
					end
					stage_pos = '0;
					stage_bad = 1'b0;
				end else begin
					stage_pos = stage_pos + 6'd1;
				end
			end
			PH_VER: begin
				if (b == VERSION_BYTE) begin
					r.event_res = EV_REPLY;
					r.reply_kind = REPLY_GREETING;
					parse_phase = PH_GREET;
				end else begin
					r.event_res = EV_ERROR;
					r.error_code = ERR_VERSION;
					parse_phase = PH_CLOSED;
				end
				stage_pos = '0;
				stage_bad = 1'b0;
			end
			PH_GREET: begin
				if (b != greet_pattern(int'(stage_pos)))
					stage_bad = 1'b1;
				if (stage_pos >= GREET_LEN - 1) begin
					if (stage_bad) begin
						r.event_res = EV_ERROR;
						r.error_code = ERR_GREETING;
						parse_phase = PH_CLOSED;
					end else begin
						r.event_res = EV_REPLY;
						r.reply_kind = REPLY_READY;
						parse_phase = PH_FLAGS;
					end
					stage_pos = '0;
					stage_bad = 1'b0;
				end else begin
					stage_pos = stage_pos + 6'd1;
				end
			end
			PH_FLAGS: begin
				frame_flags_q = b[2:0];
				len_acc = '0;
				stage_pos = '0;
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				need = frame_flags_q[FLAG_LONG_BIT] ? LONG_LEN_BYTES : SHORT_LEN_BYTES;
				len_acc = {len_acc[55:0], b};
				stage_pos = stage_pos + 6'd1;
				if (stage_pos >= need) begin
					stage_pos = '0;
					if (len_acc == 0) begin
						// zero-length command frames vanish silently
						if (!frame_flags_q[FLAG_CMD_BIT]) begin
							r.event_res = EV_EMPTY;
							r.more_frames = frame_flags_q[FLAG_MORE_BIT];
						end
						parse_phase = PH_FLAGS;
					end else begin
						pay_left = len_acc;
						parse_phase = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				if (!frame_flags_q[FLAG_CMD_BIT]) begin
					r.event_res = EV_PAYLOAD;
					r.data_byte = b;
					r.frame_last = (pay_left <= 1);
					r.more_frames = frame_flags_q[FLAG_MORE_BIT];
				end
				if (pay_left > 0)
					pay_left = pay_left - 64'd1;
				if (pay_left == 0)
					parse_phase = PH_FLAGS;
			end
			default: parse_phase = PH_CLOSED;
		endcase
		return r;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		rx_stream.push_back(b);
	endtask

	task automatic send_preamble(input run_kind_t kind);
		int bad_pos;
		logic [7:0] flip;
		logic [7:0] ver;
		bad_pos = (kind == RUN_BAD_SIG) ? $urandom_range(0, SIG_LEN - 1) : -1;
		for (int i = 0; i < SIG_LEN; i++) begin
			flip = 8'h00;
			if (kind == RUN_BAD_SIG && (i == bad_pos || $urandom_range(0, 3) == 0))
				flip = 8'($urandom_range(1, 255));
			put_byte(SIG_PATTERN[i] ^ flip);
		end
		if (kind == RUN_BAD_SIG)
			return;
		ver = VERSION_BYTE;
		if (kind == RUN_BAD_VER) begin
			do ver = 8'($urandom_range(0, 255)); while (ver == VERSION_BYTE);
		end
		put_byte(ver);
		if (kind == RUN_BAD_VER)
			return;
		bad_pos = (kind == RUN_BAD_GREET) ? $urandom_range(0, GREET_LEN - 1) : -1;
		for (int i = 0; i < GREET_LEN; i++) begin
			flip = (i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00;
			put_byte(greet_pattern(i) ^ flip);
		end
	endtask

	task automatic send_frame(input logic [7:0] flags, input logic [63:0] len);
		put_byte(flags);
		if (flags[FLAG_LONG_BIT]) begin
			for (int i = 7; i >= 0; i--)
				put_byte(len[8 * i +: 8]);
		end else begin
			put_byte(len[7:0]);
		end
		for (longint unsigned k = 0; k < len; k++)
			put_byte(8'($urandom_range(0, 255)));
	endtask

	// stimulus, reset and end of run
	initial begin
		run_kind_t kind;
		int pick;
		int target;
		logic [7:0] flags;
		logic [63:0] len;

		arst_n = 1'b0;

		// the closed state only leaves on reset, so an error run is picked now and then
		pick = $urandom_range(0, 9);
		kind = (pick == 0) ? RUN_BAD_SIG : (pick == 1) ? RUN_BAD_VER :
			(pick == 2) ? RUN_BAD_GREET : RUN_GOOD;
		send_preamble(kind);

		if (kind != RUN_GOOD) begin
			for (int i = 0; i < CLOSED_TAIL; i++)
				put_byte(8'($urandom_range(0, 255)));
		end else begin
			send_frame(8'h00, 64'd0);
			send_frame(8'h01, 64'd0);
			send_frame(8'h04, 64'd0);
			send_frame(8'h02, 64'd0);
			send_frame(8'hF9, 64'd1);
			send_frame(8'h05, 64'd2);
			send_frame(8'h03, 64'd3);
			send_frame(8'h06, 64'd1);
			target = rx_stream.size() + RANDOM_BYTES;
			while (rx_stream.size() < target) begin
				flags = 8'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick < 15)
					len = 64'd0;
				else if (pick < 90)
					len = 64'($urandom_range(1, 12));
				else if (pick < 97)
					len = 64'($urandom_range(13, 255));
				else
					len = flags[FLAG_LONG_BIT] ? 64'($urandom_range(256, 700)) : 64'd255;
				send_frame(flags, len);
			end
		end
		total_bytes = rx_stream.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < total_bytes)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// byte driver
	int tx_gap = 0;
	int tx_stretch = 0;
	bit tx_jittery = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			bytes_ch.valid <= 1'b0;
			bytes_ch.rx_byte <= 8'h00;
		end else if (!bytes_ch.valid || bytes_ch.ready) begin
			if (tx_stretch == 0) begin
				tx_stretch = $urandom_range(16, 96);
				tx_jittery = $urandom_range(0, 2) != 0;
			end
			tx_stretch--;
			if (tx_gap > 0) begin
				tx_gap--;
				bytes_ch.valid <= 1'b0;
			end else if (rx_stream.size() == 0) begin
				bytes_ch.valid <= 1'b0;
			end else if (tx_jittery && !in_tail() && $urandom_range(0, 9) == 0) begin
				tx_gap = $urandom_range(0, 5);
				bytes_ch.valid <= 1'b0;
			end else begin
				bytes_ch.valid <= 1'b1;
				bytes_ch.rx_byte <= rx_stream.pop_front();
			end
		end
	end

	// result sink back-pressure
	int rx_gap = 0;
	int rx_stretch = 0;
	bit rx_jittery = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (rx_stretch == 0) begin
				rx_stretch = $urandom_range(16, 96);
				rx_jittery = $urandom_range(0, 2) != 0;
			end
			rx_stretch--;
			if (rx_gap > 0) begin
				rx_gap--;
				res_ch.ready <= 1'b0;
			end else if (rx_jittery && !in_tail() && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 5);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on every accepted byte, check every accepted result
	always @(posedge clk) begin
		result_t exp_ev;
		if (arst_n) begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				expected_events.push_back(parse_rx(bytes_ch.rx_byte));
				bytes_taken++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: ev %0d data %02h", res_ch.event_res,
							res_ch.data_byte);
				end else begin
					exp_ev = expected_events.pop_front();
					if (res_ch.event_res !== exp_ev.event_res ||
						res_ch.data_byte !== exp_ev.data_byte ||
						res_ch.frame_last !== exp_ev.frame_last ||
						res_ch.more_frames !== exp_ev.more_frames ||
						res_ch.reply_kind !== exp_ev.reply_kind ||
						res_ch.error_code !== exp_ev.error_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: ev %0d/%0d data %02h/%02h last %0d/%0d ",
								"more %0d/%0d reply %0d/%0d err %0d/%0d (expected/actual)"},
								exp_ev.event_res, res_ch.event_res,
								exp_ev.data_byte, res_ch.data_byte,
								exp_ev.frame_last, res_ch.frame_last,
								exp_ev.more_frames, res_ch.more_frames,
								exp_ev.reply_kind, res_ch.reply_kind,
								exp_ev.error_code, res_ch.error_code);
					end
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (bytes_ch.valid && bytes_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
